FILE: rtl/tkrs_pkg.sv
// ----------------------------------------------------------------------------
// tkrs_pkg: shared definitions for the top-k running sum block
// Widths, capacity of the cell row, command codes and the cell control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package tkrs_pkg;

    // number of cells in the row, one kept value each
    localparam int CAPACITY = 1024;

    localparam int VALUE_W = 32;
    localparam int SUM_W   = 64;
    localparam int LIMIT_W = 11;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    // keep_limit after reset
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

    // command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    // operation broadcast to every cell
    typedef struct packed {
        logic insert;   // sorted insert, cells at and above the slot shift up
        logic replace;  // drop the minimum, cells below the slot shift down
    } cell_op_t;

endpackage : tkrs_pkg

`default_nettype wire

FILE: rtl/tkrs_cell.sv
// ----------------------------------------------------------------------------
// tkrs_cell: one cell of the sorted value row
// Holds one value, compares it with the offered value and trades values with
// its two neighbours on an insert or a replace of the minimum.
// ----------------------------------------------------------------------------
`default_nettype none

module tkrs_cell
    import tkrs_pkg::*;
(
    input  wire                        aclk,
    input  wire cell_op_t              op,
    input  wire logic signed [VALUE_W-1:0] item_value,
    input  wire                        occupied,
    input  wire logic signed [VALUE_W-1:0] left_value,
    input  wire                        left_lt,
    input  wire logic signed [VALUE_W-1:0] right_value,
    input  wire                        right_lt,
    output logic signed [VALUE_W-1:0]  cell_value,
    output logic                       cell_lt
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    // occupied and strictly below the offered value
    assign cell_lt    = occupied && (value_reg < item_value);
    assign cell_value = value_reg;

    // neighbour exchange
    always_comb begin
        value_next = value_reg;
        if (op.insert) begin
            if (!left_lt) begin
                value_next = left_value;
            end else if (!cell_lt) begin
                value_next = item_value;
            end
        end else if (op.replace) begin
            if (right_lt) begin
                value_next = right_value;
            end else if (cell_lt) begin
                value_next = item_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

endmodule : tkrs_cell

`default_nettype wire

FILE: rtl/top_k_running_sum.sv
// Latency: a report transaction shows its sum on m_ on the cycle after acceptance.
// Throughput: one transaction per cycle while s_ready is high; the whole cell row updates together.
// An insert is done at the edge that accepts it and gives no result.
// s_ready drops only while a sum waits on m_ and m_ready is low.
// Reset (aresetn low, synchronous) empties the row, clears the sum and
// sets keep_limit to 1024; no clearing pass is needed.
// ----------------------------------------------------------------------------
// top_k_running_sum: running sum of the largest values seen
// Keeps the largest values, up to keep_limit of them, in a sorted row of
// cells with the minimum in cell 0, and tracks their sum.
// ----------------------------------------------------------------------------
`default_nettype none

module top_k_running_sum
    import tkrs_pkg::*;
(
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         cfg_wr_en,
    input  wire [LIMIT_W-1:0]           cfg_wr_data,
    input  wire                         s_valid,
    output logic                        s_ready,
    input  wire                         s_command,
    input  wire logic signed [VALUE_W-1:0] s_value,
    output logic                        m_valid,
    input  wire                         m_ready,
    output logic signed [SUM_W-1:0]     m_kept_sum
);

    logic [LIMIT_W-1:0]        keep_limit_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [SUM_W-1:0]   sum_next;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic signed [SUM_W-1:0]   m_kept_sum_reg;

    logic [CMP_W-1:0]          limit_eff;
    logic [CMP_W-1:0]          count_ext;
    logic                      accept;
    logic                      do_insert;
    logic                      do_replace;
    cell_op_t                  op;

    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    logic                      cell_lt    [CAPACITY];
    logic signed [VALUE_W:0]   delta;

    // handshake
    assign s_ready    = !m_valid_reg || m_ready;
    assign accept     = s_valid && s_ready;
    assign m_valid    = m_valid_reg;
    assign m_kept_sum = m_kept_sum_reg;

    // limit saturated to 1..CAPACITY
    always_comb begin
        limit_eff = CMP_W'(keep_limit_reg);
        if (keep_limit_reg == '0) begin
            limit_eff = CMP_W'(1);
        end else if (CMP_W'(keep_limit_reg) > CMP_W'(CAPACITY)) begin
            limit_eff = CMP_W'(CAPACITY);
        end
    end

    assign count_ext = CMP_W'(count_reg);

    // operation decode; replace only when the value beats the minimum
    assign do_insert  = accept && (s_command == CMD_INSERT) && (count_ext < limit_eff);
    assign do_replace = accept && (s_command == CMD_INSERT) && (count_ext == limit_eff)
                        && cell_lt[0];
    assign op.insert  = do_insert;
    assign op.replace = do_replace;

    // sorted cell row
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [VALUE_W-1:0] left_value;
        logic                      left_lt;
        logic signed [VALUE_W-1:0] right_value;
        logic                      right_lt;

        if (i == 0) begin : g_first
            assign left_value = '0;
            assign left_lt    = 1'b1;
        end else begin : g_mid_l
            assign left_value = cell_value[i-1];
            assign left_lt    = cell_lt[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_value = '0;
            assign right_lt    = 1'b0;
        end else begin : g_mid_r
            assign right_value = cell_value[i+1];
            assign right_lt    = cell_lt[i+1];
        end

        tkrs_cell u_cell (
            .aclk        (aclk),
            .op          (op),
            .item_value  (s_value),
            .occupied    (count_reg > CNT_W'(i)),
            .left_value  (left_value),
            .left_lt     (left_lt),
            .right_value (right_value),
            .right_lt    (right_lt),
            .cell_value  (cell_value[i]),
            .cell_lt     (cell_lt[i])
        );
    end

    // sum and count update
    assign delta = {s_value[VALUE_W-1], s_value}
                 - {cell_value[0][VALUE_W-1], cell_value[0]};

    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (do_insert) begin
            count_next = count_reg + CNT_W'(1);
            sum_next   = sum_reg + SUM_W'(s_value);
        end else if (do_replace) begin
            sum_next   = sum_reg + SUM_W'(delta);
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept && (s_command == CMD_REPORT)) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_limit_reg <= LIMIT_RESET;
            count_reg      <= '0;
            sum_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                keep_limit_reg <= cfg_wr_data;
            end
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (s_command == CMD_REPORT)) begin
            m_kept_sum_reg <= sum_reg;
        end
    end

endmodule : top_k_running_sum

`default_nettype wire

FILE: rtl/tkrs_checker.sv
// ----------------------------------------------------------------------------
// tkrs_checker: port-level checks for the top-k running sum block
// Watches the handshakes and the reported sum over time.
// ----------------------------------------------------------------------------
`default_nettype none

module tkrs_checker
    import tkrs_pkg::*;
(
    input wire                         aclk,
    input wire                         aresetn,
    input wire                         s_valid,
    input wire                         s_ready,
    input wire                         s_command,
    input wire                         m_valid,
    input wire                         m_ready,
    input wire logic signed [SUM_W-1:0] m_kept_sum
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kept_sum))
        else $error("result changed while stalled");

    // no result straight out of reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a report transaction always yields a result
    a_report: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_command == CMD_REPORT) |=> m_valid)
        else $error("report gave no result");

    // an insert transaction yields no result
    a_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_command == CMD_INSERT) |=> !m_valid)
        else $error("insert gave a result");

    // back-to-back reports see the same sum
    a_same_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_command == CMD_REPORT)) ##1
        (s_valid && s_ready && (s_command == CMD_REPORT))
        |=> m_kept_sum == $past(m_kept_sum))
        else $error("sum changed without an insert");

endmodule : tkrs_checker

bind top_k_running_sum tkrs_checker u_tkrs_checker (.*);

`default_nettype wire
